>>> sv/cns_pkg.sv
`default_nettype none
package cns_pkg;

    // Sizes fixed by the item fields
    localparam int unsigned USER_BYTES_DEF = 48;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned REQ_W = 6;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned UPC_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INVALID = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD = 2'd1;
    localparam logic [STAT_W-1:0] ST_SUM = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TT = 1'd1;

    // Init pattern loaded by the reset command
    localparam logic [5:0] INIT_AT = 6'd8;
    localparam int unsigned INIT_LEN = 6;
    localparam logic [BYTE_W-1:0] INIT_PAT [INIT_LEN] = '{
        8'h00, 8'h2f, 8'h20, 8'hff, 8'hff, 8'hff
    };

    // Pointer operations
    localparam logic [1:0] PTR_HOLD = 2'd0;
    localparam logic [1:0] PTR_ZERO = 2'd1;
    localparam logic [1:0] PTR_START = 2'd2;
    localparam logic [1:0] PTR_INC = 2'd3;

    // Read operations (tag carried with the pending read)
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_SCAN = 2'd1;
    localparam logic [1:0] RD_STREAM = 2'd2;

    // Write operations
    localparam logic [2:0] WR_NONE = 3'd0;
    localparam logic [2:0] WR_DATA = 3'd1;
    localparam logic [2:0] WR_INIT = 3'd2;
    localparam logic [2:0] WR_CK0 = 3'd3;
    localparam logic [2:0] WR_CK1 = 3'd4;

    // Write offset operations
    localparam logic [1:0] WOFS_HOLD = 2'd0;
    localparam logic [1:0] WOFS_CLR = 2'd1;
    localparam logic [1:0] WOFS_NEXT = 2'd2;

    // Jump conditions
    localparam logic [3:0] C_NONE = 4'd0;
    localparam logic [3:0] C_ABSENT = 4'd1;
    localparam logic [3:0] C_IS_RESET = 4'd2;
    localparam logic [3:0] C_IS_BAD = 4'd3;
    localparam logic [3:0] C_IS_WRITE = 4'd4;
    localparam logic [3:0] C_SCAN_END = 4'd5;
    localparam logic [3:0] C_USER_END = 4'd6;
    localparam logic [3:0] C_SUM_BAD = 4'd7;
    localparam logic [3:0] C_WR_LAST = 4'd8;
    localparam logic [3:0] C_CNT_ONE = 4'd9;

    // Program addresses
    localparam logic [UPC_W-1:0] A_DISP = 5'd0;
    localparam logic [UPC_W-1:0] A_DRST = 5'd1;
    localparam logic [UPC_W-1:0] A_DBAD = 5'd2;
    localparam logic [UPC_W-1:0] A_DWR = 5'd3;
    localparam logic [UPC_W-1:0] A_READ = 5'd4;
    localparam logic [UPC_W-1:0] A_RSCAN = 5'd5;
    localparam logic [UPC_W-1:0] A_RDRAIN = 5'd6;
    localparam logic [UPC_W-1:0] A_RCHECK = 5'd7;
    localparam logic [UPC_W-1:0] A_STREAM = 5'd8;
    localparam logic [UPC_W-1:0] A_RDONE = 5'd9;
    localparam logic [UPC_W-1:0] A_SUMERR = 5'd10;
    localparam logic [UPC_W-1:0] A_ABSENT = 5'd11;
    localparam logic [UPC_W-1:0] A_BAD = 5'd12;
    localparam logic [UPC_W-1:0] A_RST = 5'd13;
    localparam logic [UPC_W-1:0] A_RFILL = 5'd14;
    localparam logic [UPC_W-1:0] A_RCK0 = 5'd15;
    localparam logic [UPC_W-1:0] A_RCK1 = 5'd16;
    localparam logic [UPC_W-1:0] A_WR = 5'd17;
    localparam logic [UPC_W-1:0] A_WDONE = 5'd18;
    localparam logic [UPC_W-1:0] A_WSUM = 5'd19;
    localparam logic [UPC_W-1:0] A_WSCAN = 5'd20;
    localparam logic [UPC_W-1:0] A_WDRAIN = 5'd21;
    localparam logic [UPC_W-1:0] A_WCK0 = 5'd22;
    localparam logic [UPC_W-1:0] A_WCK1 = 5'd23;

    // One control word
    typedef struct packed {
        logic [1:0] ptr_op;
        logic [1:0] rd_op;
        logic sum_clr;
        logic [2:0] wr_op;
        logic emit;
        logic [STAT_W-1:0] status;
        logic [1:0] wofs_op;
        logic [3:0] cond;
        logic neg;
        logic [UPC_W-1:0] target;
        logic fin;
    } t_uword;

    // Datapath flags tested by jumps
    typedef struct packed {
        logic absent;
        logic is_reset;
        logic is_bad;
        logic is_write;
        logic scan_end;
        logic user_end;
        logic sum_bad;
        logic wr_last;
        logic cnt_one;
    } t_flags;

    // Byte written at an address by the reset command
    function automatic logic [BYTE_W-1:0] init_byte(input logic [5:0] addr, input logic tt);
        logic [5:0] ofs;
        logic [BYTE_W-1:0] b;
        ofs = addr - INIT_AT;
        b = '0;
        if (!tt && addr >= INIT_AT && ofs < 6'(INIT_LEN)) begin
            b = INIT_PAT[ofs[2:0]];
        end
        return b;
    endfunction

    // Microprogram
    function automatic t_uword urom(input logic [UPC_W-1:0] upc);
        t_uword uw;
        uw = '0;
        case (upc)
            A_DISP: begin
                uw.cond = C_ABSENT;
                uw.target = A_ABSENT;
            end
            A_DRST: begin
                uw.cond = C_IS_RESET;
                uw.target = A_RST;
            end
            A_DBAD: begin
                uw.cond = C_IS_BAD;
                uw.target = A_BAD;
            end
            A_DWR: begin
                uw.cond = C_IS_WRITE;
                uw.target = A_WR;
            end
            A_READ: begin
                uw.ptr_op = PTR_ZERO;
                uw.sum_clr = 1'b1;
                uw.wofs_op = WOFS_CLR;
            end
            A_RSCAN: begin
                uw.rd_op = RD_SCAN;
                uw.ptr_op = PTR_INC;
                uw.cond = C_SCAN_END;
                uw.neg = 1'b1;
                uw.target = A_RSCAN;
            end
            A_RDRAIN: begin
                uw.cond = C_NONE;
            end
            A_RCHECK: begin
                uw.ptr_op = PTR_START;
                uw.cond = C_SUM_BAD;
                uw.target = A_SUMERR;
            end
            A_STREAM: begin
                uw.rd_op = RD_STREAM;
                uw.ptr_op = PTR_INC;
                uw.cond = C_CNT_ONE;
                uw.neg = 1'b1;
                uw.target = A_STREAM;
            end
            A_RDONE: begin
                uw.fin = 1'b1;
            end
            A_SUMERR: begin
                uw.emit = 1'b1;
                uw.status = ST_SUM;
                uw.fin = 1'b1;
            end
            A_ABSENT: begin
                uw.emit = 1'b1;
                uw.status = ST_ABSENT;
                uw.wofs_op = WOFS_CLR;
                uw.fin = 1'b1;
            end
            A_BAD: begin
                uw.emit = 1'b1;
                uw.status = ST_BAD;
                uw.wofs_op = WOFS_CLR;
                uw.fin = 1'b1;
            end
            A_RST: begin
                uw.ptr_op = PTR_ZERO;
                uw.sum_clr = 1'b1;
                uw.wofs_op = WOFS_CLR;
            end
            A_RFILL: begin
                uw.wr_op = WR_INIT;
                uw.ptr_op = PTR_INC;
                uw.cond = C_USER_END;
                uw.neg = 1'b1;
                uw.target = A_RFILL;
            end
            A_RCK0: begin
                uw.wr_op = WR_CK0;
            end
            A_RCK1: begin
                uw.wr_op = WR_CK1;
                uw.emit = 1'b1;
                uw.status = ST_OK;
                uw.fin = 1'b1;
            end
            A_WR: begin
                uw.wr_op = WR_DATA;
                uw.wofs_op = WOFS_NEXT;
                uw.cond = C_WR_LAST;
                uw.target = A_WSUM;
            end
            A_WDONE: begin
                uw.fin = 1'b1;
            end
            A_WSUM: begin
                uw.ptr_op = PTR_ZERO;
                uw.sum_clr = 1'b1;
            end
            A_WSCAN: begin
                uw.rd_op = RD_SCAN;
                uw.ptr_op = PTR_INC;
                uw.cond = C_USER_END;
                uw.neg = 1'b1;
                uw.target = A_WSCAN;
            end
            A_WDRAIN: begin
                uw.cond = C_NONE;
            end
            A_WCK0: begin
                uw.wr_op = WR_CK0;
            end
            A_WCK1: begin
                uw.wr_op = WR_CK1;
                uw.emit = 1'b1;
                uw.status = ST_OK;
                uw.fin = 1'b1;
            end
            default: begin
                uw.fin = 1'b1;
            end
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

>>> sv/cns_ram.sv
`default_nettype none
module cns_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 50
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/cns_seq.sv
`default_nettype none
module cns_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire cns_pkg::t_flags i_flags,
    output cns_pkg::t_uword     o_uw,
    output logic                o_busy
);

    logic [cns_pkg::UPC_W-1:0] r_upc;
    logic [cns_pkg::UPC_W-1:0] n_upc;
    logic r_run;
    logic n_run;
    cns_pkg::t_uword uw;
    logic hit;

    // Fetch the current control word; idle issues a blank word
    always_comb begin
        uw = cns_pkg::urom(r_upc);
        o_uw = r_run ? uw : '0;
    end

    // Evaluate the jump condition
    always_comb begin
        case (uw.cond)
            cns_pkg::C_NONE:     hit = 1'b0;
            cns_pkg::C_ABSENT:   hit = i_flags.absent;
            cns_pkg::C_IS_RESET: hit = i_flags.is_reset;
            cns_pkg::C_IS_BAD:   hit = i_flags.is_bad;
            cns_pkg::C_IS_WRITE: hit = i_flags.is_write;
            cns_pkg::C_SCAN_END: hit = i_flags.scan_end;
            cns_pkg::C_USER_END: hit = i_flags.user_end;
            cns_pkg::C_SUM_BAD:  hit = i_flags.sum_bad;
            cns_pkg::C_WR_LAST:  hit = i_flags.wr_last;
            cns_pkg::C_CNT_ONE:  hit = i_flags.cnt_one;
            default:             hit = 1'b0;
        endcase
    end

    // Advance the step counter: start, jump, fall through or stop
    always_comb begin
        n_upc = r_upc;
        n_run = r_run;
        if (i_go) begin
            n_upc = cns_pkg::A_DISP;
            n_run = 1'b1;
        end else if (r_run) begin
            if (uw.fin) begin
                n_run = 1'b0;
            end else if (uw.cond != cns_pkg::C_NONE && (hit ^ uw.neg)) begin
                n_upc = uw.target;
            end else begin
                n_upc = r_upc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= cns_pkg::A_DISP;
            r_run <= 1'b0;
        end else begin
            r_upc <= n_upc;
            r_run <= n_run;
        end
    end

    assign o_busy = r_run;

endmodule
`default_nettype wire

>>> sv/checksummed_nvram_store.sv
`default_nettype none
// Checksummed byte store: USER_BYTES user bytes followed by a checksum pair
// (complemented and plain 8-bit sum). A request is taken when start is high
// and busy is low; results come out one per cycle on o_strobe and cannot be
// held off, so the receiver must take every strobed cycle. A read walks the
// whole store, checksum pair included, to verify it; a write item that is
// not the last of its request writes its byte, and the last one also
// rebuilds the checksum; a reset command rewrites all user bytes. When the
// device is absent, or for a bad range or an invalid command, only a status
// is reported. An emitted status is registered in the cycle after the
// control step that makes it; streamed read data is registered first in
// the RAM read port and then in the result register. The final result of
// a request falls in the first cycle after busy drops. The microcode steps
// through the byte RAM one address per cycle. After power-on reset the
// store reads as all zeros (so a read reports a checksum error until a
// reset command or a completed write).
module checksummed_nvram_store #(
    parameter int unsigned USER_BYTES = cns_pkg::USER_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [cns_pkg::CMD_W-1:0]    i_command,
    input  wire logic [cns_pkg::REQ_W-1:0]    i_start_req,
    input  wire logic [cns_pkg::REQ_W-1:0]    i_count,
    input  wire logic [cns_pkg::BYTE_W-1:0]   i_write_data,
    output logic                              o_strobe,
    output logic [cns_pkg::BYTE_W-1:0]        o_read_data,
    output logic [cns_pkg::STAT_W-1:0]        o_status,
    output logic                              o_last,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [cns_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                         i_cfg_data
);

    localparam int unsigned DEPTH = USER_BYTES + 2;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_USER = AW'(USER_BYTES - 1);
    localparam logic [AW-1:0] CK0_ADDR = AW'(USER_BYTES);
    localparam logic [AW-1:0] CK1_ADDR = AW'(USER_BYTES + 1);
    localparam int unsigned BW = cns_pkg::BYTE_W;
    localparam int unsigned RW = cns_pkg::REQ_W;

    logic go;
    cns_pkg::t_uword uw;
    cns_pkg::t_flags flags;

    // Configuration
    logic r_present;
    logic r_tt;

    // Latched request
    logic [cns_pkg::CMD_W-1:0] r_cmd;
    logic [RW-1:0] r_start;
    logic [RW-1:0] r_count;
    logic [BW-1:0] r_wdata;

    // Datapath registers
    logic [AW-1:0] r_ptr;
    logic [RW-1:0] r_cnt;
    logic [RW-1:0] r_wofs;
    logic [BW-1:0] r_sum;
    logic [BW-1:0] r_ck0;
    logic [BW-1:0] r_ck1;
    logic [DEPTH-1:0] r_vld;
    logic [1:0] r_pend_kind;
    logic [AW-1:0] r_pend_addr;
    logic r_pend_last;
    logic r_rd_vld;

    // Output registers
    logic r_strobe;
    logic [BW-1:0] r_rdata;
    logic [cns_pkg::STAT_W-1:0] r_status;
    logic r_last;

    // Combinational datapath
    logic [RW-1:0] pos;
    logic wr_last;
    logic range_ok;
    logic [BW-1:0] ini;
    logic [BW-1:0] rd_byte;
    logic [BW-1:0] ram_q;
    logic we;
    logic [AW-1:0] waddr;
    logic [BW-1:0] wdata;
    logic re;
    logic [RW:0] wpos_addr;

    assign go = start && !busy;
    assign o_cfg_ready = 1'b1;

    cns_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_flags (flags),
        .o_uw    (uw),
        .o_busy  (busy)
    );

    cns_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_ptr),
        .o_rdata (ram_q)
    );

    // Decode request and build jump flags
    always_comb begin
        pos = (r_wofs >= r_count) ? '0 : r_wofs;
        wr_last = (pos + 1'b1) == r_count;
        range_ok = (r_count != '0)
            && ((7'(r_start) + 7'(r_count)) <= 7'(USER_BYTES));
        flags.absent = !r_present;
        flags.is_reset = r_cmd == cns_pkg::CMD_RESET;
        flags.is_bad = (r_cmd == cns_pkg::CMD_INVALID) || !range_ok;
        flags.is_write = r_cmd == cns_pkg::CMD_WRITE;
        flags.scan_end = r_ptr == CK1_ADDR;
        flags.user_end = r_ptr == LAST_USER;
        flags.sum_bad = (r_ck0 != ~r_sum) || (r_ck1 != r_sum);
        flags.wr_last = wr_last;
        flags.cnt_one = r_cnt == RW'(1);
    end

    // Select the RAM write
    always_comb begin
        ini = cns_pkg::init_byte(6'(r_ptr), r_tt);
        wpos_addr = 7'(r_start) + 7'(pos);
        we = uw.wr_op != cns_pkg::WR_NONE;
        re = uw.rd_op != cns_pkg::RD_NONE;
        case (uw.wr_op)
            cns_pkg::WR_DATA: begin
                waddr = wpos_addr[AW-1:0];
                wdata = r_wdata;
            end
            cns_pkg::WR_INIT: begin
                waddr = r_ptr;
                wdata = ini;
            end
            cns_pkg::WR_CK0: begin
                waddr = CK0_ADDR;
                wdata = ~r_sum;
            end
            cns_pkg::WR_CK1: begin
                waddr = CK1_ADDR;
                wdata = r_sum;
            end
            default: begin
                waddr = r_ptr;
                wdata = r_wdata;
            end
        endcase
        rd_byte = r_rd_vld ? ram_q : '0;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b1;
            r_tt <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cns_pkg::CFG_PRESENT: r_present <= i_cfg_data;
                cns_pkg::CFG_TT:      r_tt <= i_cfg_data;
                default:              r_tt <= r_tt;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_cmd <= i_command;
            r_start <= i_start_req;
            r_count <= i_count;
            r_wdata <= i_write_data;
        end
    end

    // Pointer and stream counter
    always_ff @(posedge i_clk) begin
        case (uw.ptr_op)
            cns_pkg::PTR_ZERO: r_ptr <= '0;
            cns_pkg::PTR_START: begin
                r_ptr <= r_start[AW-1:0];
                r_cnt <= r_count;
            end
            cns_pkg::PTR_INC: begin
                r_ptr <= r_ptr + 1'b1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: r_ptr <= r_ptr;
        endcase
    end

    // Write offset within a write request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wofs <= '0;
        end else begin
            case (uw.wofs_op)
                cns_pkg::WOFS_CLR:  r_wofs <= '0;
                cns_pkg::WOFS_NEXT: r_wofs <= wr_last ? '0 : pos + 1'b1;
                default:            r_wofs <= r_wofs;
            endcase
        end
    end

    // Valid bits: unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[waddr] <= 1'b1;
        end
    end

    // Track the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_kind <= cns_pkg::RD_NONE;
        end else begin
            r_pend_kind <= uw.rd_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_pend_addr <= r_ptr;
            r_pend_last <= r_cnt == RW'(1);
            r_rd_vld <= r_vld[r_ptr];
        end
    end

    // Sum and stored checksum capture
    always_ff @(posedge i_clk) begin
        if (uw.sum_clr) begin
            r_sum <= '0;
        end else if (uw.wr_op == cns_pkg::WR_INIT) begin
            r_sum <= r_sum + ini;
        end else if (r_pend_kind == cns_pkg::RD_SCAN) begin
            if (r_pend_addr == CK0_ADDR) begin
                r_ck0 <= rd_byte;
            end else if (r_pend_addr == CK1_ADDR) begin
                r_ck1 <= rd_byte;
            end else begin
                r_sum <= r_sum + rd_byte;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= uw.emit || (r_pend_kind == cns_pkg::RD_STREAM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.emit) begin
            r_rdata <= '0;
            r_status <= uw.status;
            r_last <= 1'b1;
        end else if (r_pend_kind == cns_pkg::RD_STREAM) begin
            r_rdata <= rd_byte;
            r_status <= cns_pkg::ST_OK;
            r_last <= r_pend_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_read_data = r_rdata;
    assign o_status = r_status;
    assign o_last = r_last;

endmodule
`default_nettype wire
